// File: hw/rtl/dq_pkg.sv
// Package for the double-ended queue core: sizes, request and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 8;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Controller -> datapath
    typedef struct packed {
        logic exec;      // perform the request on the input bus
        logic load_pop;  // capture RAM read data as the popped byte
    } dq_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic pop_ok;    // request on the input bus is a pop that will read
    } dq_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dq_ctrl.sv
// Controller FSM for the double-ended queue core: sequences accept, RAM read
// and result hand-off. Depends on dq_pkg.
`default_nettype none

module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire dq_stat_t stat,
    output dq_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.exec     = 1'b0;
        cmd.load_pop = 1'b0;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.pop_ok ? S_READ : S_DONE;
                end
            end
            S_READ:
            begin
                cmd.load_pop = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/dq_datapath.sv
// Datapath of the double-ended queue core: ring indices, entry count, entry
// RAM and result registers. Depends on dq_pkg and dq_ram.
`default_nettype none

module dq_datapath
    import dq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [DATA_W-1:0] value,
    input  wire dq_cmd_t           cmd,
    output dq_stat_t               stat,
    output logic      [STAT_W-1:0] status,
    output logic      [DATA_W-1:0] popped,
    output logic      [OCC_W-1:0]  occupancy
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0]  front_reg, front_next;
    logic [IDX_W-1:0]  back_reg, back_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] popped_reg;
    logic [OCC_W-1:0]  occ_reg;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              is_full, is_empty;
    logic [IDX_W-1:0]  front_inc, front_dec, back_inc, back_dec;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign back_inc  = (back_reg == LAST_IDX) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? LAST_IDX : back_reg - 1'b1;

    assign stat.pop_ok = kind[1] && !is_empty;

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = back_reg;
        ram_raddr   = front_reg;
        case (kind)
            KIND_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ram_we     = cmd.exec;
                    ram_waddr  = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ram_we     = cmd.exec;
                    ram_waddr  = back_reg;
                    back_next  = back_inc;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    ram_re     = cmd.exec;
                    ram_raddr  = front_reg;
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    ram_re     = cmd.exec;
                    ram_raddr  = back_dec;
                    back_next  = back_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Result registers, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            occ_reg    <= OCC_W'(count_next);
            popped_reg <= '0;
        end
        else if (cmd.load_pop)
        begin
            popped_reg <= ram_rdata;
        end
    end

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status    = status_reg;
    assign popped    = popped_reg;
    assign occupancy = occ_reg;

endmodule

`default_nettype wire

// File: hw/rtl/double_ended_queue_core.sv
// Top level of the double-ended queue core: stream ports, controller and
// datapath. Depends on dq_pkg, dq_ctrl, dq_datapath (and dq_ram below it).
//
//  Channel   Direction  Payload
//  --------  ---------  ---------------------------------------------------
//  s_axis    in         tuser: kind[1:0]; tdata: value[7:0]
//  m_axis    out        tuser: status[1:0]; tdata: popped[7:0], occupancy[12:8]
//
// One request at a time: a push shows its result valid in the cycle after the
// transfer in; a pop that reads an entry first passes through a read state,
// for the registered read port of the entry RAM. The next request is taken in
// the cycle after the result transfer. rst_n clears the indices, the count and
// the controller; entry contents are kept only as written. A stalled result
// (m_tready low) holds its payload and blocks new requests.
`default_nettype none

module double_ended_queue_core
    import dq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] value, [15:8] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] popped, [12:8] occupancy, [15:13] zero
    output logic      [1:0]  m_tuser    // [1:0] status
);

    dq_cmd_t           cmd;
    dq_stat_t          stat;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] popped;
    logic [OCC_W-1:0]  occupancy;

    // Sequencer: accept, optional RAM read, result hand-off
    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Ring buffer state and result registers
    dq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .kind      (s_tuser[KIND_W-1:0]),
        .value     (s_tdata[DATA_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .status    (status),
        .popped    (popped),
        .occupancy (occupancy)
    );

    assign m_tdata = {3'b000, occupancy, popped};
    assign m_tuser = status;

endmodule

`default_nettype wire

// File: hw/rtl/dq_checker.sv
// Port-level checker for double_ended_queue_core, bound to the top level.
// Depends on dq_pkg.
`default_nettype none

module dq_checker
    import dq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One request in flight: no intake while a result is shown
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // After an input transfer the block is busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted twice in a row");

    // Refused requests report no byte
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero byte on refused request");

    // Status code legal
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_EMPTY || m_tuser == STAT_FULL))
        else $error("illegal status code");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for double_ended_queue_core: a directed table and a
// biased random request stream, each result checked against a typed-in or
// predicted value. Depends on dq_pkg and the RTL of the double-ended queue core.

module testbench;

    import dq_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int N_RANDOM   = 500;
    localparam int CYCLE_CAP  = 200000;   // far above the slowest passing run
    localparam int HOLD_LEN   = 60;       // long output stall, blocks new requests
    localparam int HOLD_AT    = 150;      // accepted requests before that stall
    localparam int DRAIN_WAIT = 10;

    // One result as it appears on m_tuser/m_tdata
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] popped;
        logic [OCC_W-1:0]  occupancy;
    } dq_result_t;

    // One request, optionally with its result typed in by hand
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        bit                typed;
        dq_result_t        want;
    } dq_request_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] value, [15:8] zero
    logic [1:0]  s_tuser  = '0;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [7:0] popped, [12:8] occupancy, [15:13] zero
    logic [1:0]  m_tuser;         // [1:0] status

    // Predictor state: ring of bytes, front slot, slot past the back, count
    logic [DATA_W-1:0] ring [DEPTH];
    int                front_slot = 0;
    int                back_slot  = 0;
    int                held_count = 0;

    dq_request_t requests_in_flight[$];   // offered, not yet transferred
    dq_result_t  pending_results[$];      // transferred, result not yet seen
    dq_request_t directed_rows[$];

    int  n_fail     = 0;
    int  n_accepted = 0;
    int  n_results  = 0;
    int  n_full     = 0;
    int  n_empty    = 0;
    int  n_popped   = 0;
    int  n_cycles   = 0;
    bit  calm       = 1'b0;   // both sides run without idling while set
    bit  hold_done  = 1'b0;
    int  hold_left  = 0;

    double_ended_queue_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Deque behavior: apply one request to the predictor state, return result.
    // Refused requests (full push, empty pop) leave the state alone.
    function automatic dq_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input logic [DATA_W-1:0] value);
        dq_result_t r;
        r.status = STAT_OK;
        r.popped = '0;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (held_count >= DEPTH)
                    r.status = STAT_FULL;
                else if (kind == KIND_PUSH_FRONT)
                begin
                    front_slot       = (front_slot == 0) ? DEPTH - 1 : front_slot - 1;
                    ring[front_slot] = value;
                    held_count++;
                end
                else
                begin
                    ring[back_slot] = value;
                    back_slot       = (back_slot == DEPTH - 1) ? 0 : back_slot + 1;
                    held_count++;
                end
            end
            default:
            begin
                if (held_count == 0)
                    r.status = STAT_EMPTY;
                else if (kind == KIND_POP_FRONT)
                begin
                    r.popped   = ring[front_slot];
                    front_slot = (front_slot == DEPTH - 1) ? 0 : front_slot + 1;
                    held_count--;
                end
                else
                begin
                    back_slot = (back_slot == 0) ? DEPTH - 1 : back_slot - 1;
                    r.popped  = ring[back_slot];
                    held_count--;
                end
            end
        endcase
        r.occupancy = OCC_W'(held_count);
        return r;
    endfunction

    function automatic void add_row(input logic [KIND_W-1:0] kind,
                                    input logic [DATA_W-1:0] value,
                                    input bit typed,
                                    input logic [STAT_W-1:0] status,
                                    input logic [DATA_W-1:0] popped,
                                    input logic [OCC_W-1:0] occupancy);
        dq_request_t row;
        row.kind           = kind;
        row.value          = value;
        row.typed          = typed;
        row.want.status    = status;
        row.want.popped    = popped;
        row.want.occupancy = occupancy;
        directed_rows.push_back(row);
    endfunction

    // Offer one request and hold it until the transfer. Called at a rising
    // edge; returns at the edge where the transfer took place.
    task automatic offer(input dq_request_t req);
        int gap;
        if (!calm && $urandom_range(99) < 35)
        begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        requests_in_flight.push_back(req);
        s_tvalid <= 1'b1;
        s_tuser  <= req.kind;
        s_tdata  <= {8'h00, req.value};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Drop valid and wait until every transferred request has its result
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge clk);
        while (pending_results.size() != 0 || requests_in_flight.size() != 0);
    endtask

    // Monitor: check the result transfer first, then predict for the request
    // transfer, so a result can never match an expectation of the same edge.
    always @(posedge clk)
    begin : monitor
        dq_result_t  want;
        dq_request_t req;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing pending: status %0d data %h",
                           m_tuser, m_tdata);
                    n_fail++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        n_fail++;
                    end
                    if (m_tdata[7:0] !== want.popped)
                    begin
                        $error("popped: expected %h, got %h", want.popped, m_tdata[7:0]);
                        n_fail++;
                    end
                    if (m_tdata[12:8] !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, m_tdata[12:8]);
                        n_fail++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                n_accepted++;
                if (requests_in_flight.size() == 0)
                begin
                    $error("request transfer with nothing offered");
                    n_fail++;
                end
                else
                begin
                    req  = requests_in_flight.pop_front();
                    want = apply_request(req.kind, req.value);
                    if (want.status == STAT_FULL)
                        n_full++;
                    else if (want.status == STAT_EMPTY)
                        n_empty++;
                    else if (req.kind == KIND_POP_FRONT || req.kind == KIND_POP_BACK)
                        n_popped++;
                    pending_results.push_back(req.typed ? req.want : want);
                end
            end
        end
    end

    // Receiver: random stalls, none while calm, one long hold-off mid-run
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && n_accepted >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 35);
    end

    // Watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles == CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     n_cycles, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        dq_request_t req;
        int          push_pct;
        int          pick;

        // Empty pops, a push/pop at each end with extreme bytes, then fill until
        // full (front pushes wrap the front index), push on full and pop at the back.
        add_row(KIND_POP_FRONT,  8'h5A, 1'b1, STAT_EMPTY, 8'h00, 5'd0);
        add_row(KIND_POP_BACK,   8'hA5, 1'b1, STAT_EMPTY, 8'h00, 5'd0);
        add_row(KIND_PUSH_FRONT, 8'hFF, 1'b1, STAT_OK,    8'h00, 5'd1);
        add_row(KIND_PUSH_BACK,  8'h00, 1'b1, STAT_OK,    8'h00, 5'd2);
        add_row(KIND_POP_FRONT,  8'h00, 1'b1, STAT_OK,    8'hFF, 5'd1);
        add_row(KIND_POP_BACK,   8'hFF, 1'b1, STAT_OK,    8'h00, 5'd0);
        for (int i = 0; i < DEPTH; i++)
            add_row((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                    DATA_W'(8'h11 * i + 8'h0F), 1'b0, STAT_OK, '0, '0);
        add_row(KIND_PUSH_BACK,  8'hFF, 1'b1, STAT_FULL,  8'h00, 5'd16);
        add_row(KIND_PUSH_FRONT, 8'h00, 1'b1, STAT_FULL,  8'h00, 5'd16);
        add_row(KIND_POP_BACK,   8'h00, 1'b0, STAT_OK,    8'h00, 5'd0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i]);

        // Sender pause: let the core go idle before the random part
        drain();

        push_pct = 50;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Bias changes in blocks so the deque swings between full and empty
            if (i % 32 == 0)
            begin
                pick = $urandom_range(4);
                push_pct = (pick == 0) ? 92 : (pick == 1) ? 75 : (pick == 2) ? 50 :
                           (pick == 3) ? 25 : 8;
            end
            calm = (i >= 250 && i < 330);
            if (i == 400)
                drain();
            if ($urandom_range(99) < push_pct)
                req.kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
            else
                req.kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
            pick = $urandom_range(9);
            req.value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
                        DATA_W'($urandom_range(255));
            req.typed = 1'b0;
            req.want  = '0;
            offer(req);
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests, %0d results: %0d bytes popped, %0d full pushes, %0d empty pops",
                 n_accepted, n_results, n_popped, n_full, n_empty);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
